// File: design/c128p_pkg.sv
`default_nettype none

package c128p_pkg;

   // Input and codeword geometry
   localparam int NUM_DIGITS   = 14;
   localparam int DIGITS_WIDTH = 4 * NUM_DIGITS;
   localparam int NUM_PAIRS    = 7;
   localparam int NUM_SYMBOLS  = NUM_PAIRS + 1;   // data pairs plus check symbol
   localparam int CW_WIDTH     = 7;
   localparam int PAIR_LIMIT   = 96;
   localparam int CHECK_MOD    = 103;

   // Weighted sum peaks at 95 * 22 = 2090; garbage pairs still stay below 4096
   localparam int SUM_WIDTH    = 12;

   // floor(sum / 103) as (sum * RECIP) >> RECIP_SHIFT, exact for sums up to 2788,
   // which covers every well-formed number
   localparam int RECIP        = 2546;
   localparam int RECIP_SHIFT  = 18;
   localparam int PROD_WIDTH   = 24;
   localparam int QUOT_WIDTH   = PROD_WIDTH - RECIP_SHIFT;

   // Element counts per symbol
   localparam int CW_ELEMS     = 6;
   localparam int STOP_ELEMS   = 7;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
   localparam logic [1:0] STATUS_BAD_PAIR  = 2'd2;

   typedef logic [CW_WIDTH-1:0] codeword_type;

   // One classified number: status and the eight symbol values (check last)
   typedef struct packed {
      logic [1:0]                          status;
      logic [NUM_SYMBOLS-1:0][CW_WIDTH-1:0] cw;
   } entry_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   // Bar/space widths, one hex digit per element, first element in the top digit
   localparam logic [23:0] WIDTH_TABLE [0:CHECK_MOD-1] = '{
      24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322, 24'h131222, 24'h122213,
      24'h122312, 24'h132212, 24'h221213, 24'h221312, 24'h231212, 24'h112232, 24'h122132,
      24'h122231, 24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132, 24'h221231,
      24'h213212, 24'h223112, 24'h312131, 24'h311222, 24'h321122, 24'h321221, 24'h312212,
      24'h322112, 24'h322211, 24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
      24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313, 24'h231113, 24'h231311,
      24'h112133, 24'h112331, 24'h132131, 24'h113123, 24'h113321, 24'h133121, 24'h313121,
      24'h211331, 24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123, 24'h311321,
      24'h331121, 24'h312113, 24'h312311, 24'h332111, 24'h314111, 24'h221411, 24'h431111,
      24'h111224, 24'h111422, 24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
      24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211, 24'h241211, 24'h221114,
      24'h413111, 24'h241112, 24'h134111, 24'h111242, 24'h121142, 24'h121241, 24'h114212,
      24'h124112, 24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141, 24'h214121,
      24'h412121, 24'h111143, 24'h111341, 24'h131141, 24'h114113, 24'h114311, 24'h411113,
      24'h411311, 24'h113141, 24'h114131, 24'h311141, 24'h411131
   };

   localparam logic [27:0] STOP_PATTERN = 28'h2331112;

endpackage

`default_nettype wire

// File: design/c128p_front.sv
`default_nettype none

module c128p_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire logic [c128p_pkg::DIGITS_WIDTH-1:0]    in_digits,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output c128p_pkg::entry_type                       out_entry
);

   localparam int NP  = c128p_pkg::NUM_PAIRS;
   localparam int CWW = c128p_pkg::CW_WIDTH;
   localparam int SW  = c128p_pkg::SUM_WIDTH;
   localparam int QW  = c128p_pkg::QUOT_WIDTH;
   localparam int PW  = c128p_pkg::PROD_WIDTH;

   // Stage 1: codewords and status
   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_status_ff, s1_status_in;
   logic [NP-1:0][CWW-1:0]  s1_cw_ff, s1_cw_in;
   // Stage 2: weighted sum
   logic                    s2_valid_ff, s2_valid_in;
   logic [1:0]              s2_status_ff;
   logic [NP-1:0][CWW-1:0]  s2_cw_ff;
   logic [SW-1:0]           s2_sum_ff, s2_sum_in;
   // Stage 3: quotient by 103
   logic                    s3_valid_ff, s3_valid_in;
   logic [1:0]              s3_status_ff;
   logic [NP-1:0][CWW-1:0]  s3_cw_ff;
   logic [SW-1:0]           s3_sum_ff;
   logic [QW-1:0]           s3_quot_ff, s3_quot_in;

   logic                    s1_ready, s2_ready, s3_ready;
   logic [PW-1:0]           prod;
   logic [SW-1:0]           rem;

   // Stall chain: a stage loads when empty or when its content moves on
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Split nibbles, form pairs, classify
   always_comb begin
      logic [3:0] hi, lo;
      logic [7:0] pair;
      logic       bad_digit, bad_pair;
      bad_digit = 1'b0;
      bad_pair  = 1'b0;
      for (int p = 0; p < NP; p++) begin
         hi = in_digits[4*(2*NP-1-2*p) +: 4];
         lo = in_digits[4*(2*NP-2-2*p) +: 4];
         if (hi > 4'd9 || lo > 4'd9) bad_digit = 1'b1;
         pair = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
         if (pair >= 8'(c128p_pkg::PAIR_LIMIT)) bad_pair = 1'b1;
         s1_cw_in[p] = pair[CWW-1:0];
      end
      if (bad_digit) begin
         s1_status_in = c128p_pkg::STATUS_BAD_DIGIT;
      end else if (bad_pair) begin
         s1_status_in = c128p_pkg::STATUS_BAD_PAIR;
      end else begin
         s1_status_in = c128p_pkg::STATUS_OK;
      end
   end

   // Check sum: first codeword plus each later one times its position
   always_comb begin
      s2_sum_in = SW'(s1_cw_ff[0]);
      for (int p = 1; p < NP; p++) begin
         s2_sum_in = s2_sum_in + SW'(SW'(s1_cw_ff[p]) * SW'(p));
      end
   end

   // Quotient by reciprocal multiply
   assign prod       = PW'(s2_sum_ff) * PW'(c128p_pkg::RECIP);
   assign s3_quot_in = prod[PW-1:c128p_pkg::RECIP_SHIFT];

   // Remainder from the registered quotient
   assign rem = s3_sum_ff - SW'(SW'(s3_quot_ff) * SW'(c128p_pkg::CHECK_MOD));

   always_comb begin
      out_entry.status = s3_status_ff;
      for (int p = 0; p < NP; p++) begin
         out_entry.cw[p] = s3_cw_ff[p];
      end
      out_entry.cw[NP] = rem[CWW-1:0];
   end
   assign out_valid = s3_valid_ff;

   // Valid bits
   assign s1_valid_in = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_status_ff <= s1_status_in;
         s1_cw_ff     <= s1_cw_in;
      end
      if (s2_ready) begin
         s2_status_ff <= s1_status_ff;
         s2_cw_ff     <= s1_cw_ff;
         s2_sum_ff    <= s2_sum_in;
      end
      if (s3_ready) begin
         s3_status_ff <= s2_status_ff;
         s3_cw_ff     <= s2_cw_ff;
         s3_sum_ff    <= s2_sum_ff;
         s3_quot_ff   <= s3_quot_in;
      end
   end

endmodule

`default_nettype wire

// File: design/c128p_queue.sv
`default_nettype none

module c128p_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire c128p_pkg::entry_type  push_entry,
   output c128p_pkg::queue_head_type  head,
   input  wire logic                  pop
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   c128p_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(DEPTH));
   assign push       = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store on transfer
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/c128p_back.sv
`default_nettype none

module c128p_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire c128p_pkg::queue_head_type  head,
   output logic                            pop,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [2:0]                      out_width,
   output logic                            out_bar,
   output logic [1:0]                      out_status,
   output logic                            out_last
);

   localparam int NP = c128p_pkg::NUM_PAIRS;

   logic [3:0] sym_ff, sym_in;     // 0..7 codewords and check, 8 is stop
   logic [2:0] elem_ff, elem_in;
   logic       valid_ff, valid_in;
   logic [2:0] width_ff, width_in;
   logic       bar_ff, bar_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;

   logic        slot_free, emit, is_error, in_stop;
   logic [c128p_pkg::CW_WIDTH-1:0] cw_sel;
   logic [23:0] pattern;
   logic [3:0]  nib;

   assign slot_free = !valid_ff || out_ready;
   assign emit      = head.valid && slot_free;
   assign is_error  = (head.entry.status != c128p_pkg::STATUS_OK);
   assign in_stop   = (sym_ff == 4'(c128p_pkg::NUM_SYMBOLS));

   // Look up the current symbol's widths
   assign cw_sel  = head.entry.cw[sym_ff[2:0]];
   assign pattern = c128p_pkg::WIDTH_TABLE[cw_sel];

   // Pick the current element's width
   always_comb begin
      if (in_stop) begin
         case (elem_ff)
            3'd0:    nib = c128p_pkg::STOP_PATTERN[27:24];
            3'd1:    nib = c128p_pkg::STOP_PATTERN[23:20];
            3'd2:    nib = c128p_pkg::STOP_PATTERN[19:16];
            3'd3:    nib = c128p_pkg::STOP_PATTERN[15:12];
            3'd4:    nib = c128p_pkg::STOP_PATTERN[11:8];
            3'd5:    nib = c128p_pkg::STOP_PATTERN[7:4];
            default: nib = c128p_pkg::STOP_PATTERN[3:0];
         endcase
      end else begin
         case (elem_ff)
            3'd0:    nib = pattern[23:20];
            3'd1:    nib = pattern[19:16];
            3'd2:    nib = pattern[15:12];
            3'd3:    nib = pattern[11:8];
            3'd4:    nib = pattern[7:4];
            default: nib = pattern[3:0];
         endcase
      end
   end

   // Form the next element and step the counters
   always_comb begin
      sym_in    = sym_ff;
      elem_in   = elem_ff;
      pop       = 1'b0;
      valid_in  = slot_free ? 1'b0 : valid_ff;
      width_in  = width_ff;
      bar_in    = bar_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         if (is_error) begin
            width_in  = 3'd0;
            bar_in    = 1'b0;
            status_in = head.entry.status;
            last_in   = 1'b1;
            pop       = 1'b1;
            sym_in    = '0;
            elem_in   = '0;
         end else begin
            width_in  = nib[2:0];
            bar_in    = !elem_ff[0];
            status_in = c128p_pkg::STATUS_OK;
            last_in   = in_stop && (elem_ff == 3'(c128p_pkg::STOP_ELEMS - 1));
            if (in_stop) begin
               if (elem_ff == 3'(c128p_pkg::STOP_ELEMS - 1)) begin
                  pop     = 1'b1;
                  sym_in  = '0;
                  elem_in = '0;
               end else begin
                  elem_in = elem_ff + 1'b1;
               end
            end else if (elem_ff == 3'(c128p_pkg::CW_ELEMS - 1)) begin
               sym_in  = sym_ff + 1'b1;
               elem_in = '0;
            end else begin
               elem_in = elem_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff   <= '0;
         elem_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sym_ff   <= sym_in;
         elem_ff  <= elem_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      bar_ff    <= bar_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_width  = width_ff;
   assign out_bar    = bar_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

   // Symbols are counted over data pairs, check and stop
   if (NP + 2 > 16) begin : g_sym_range
      $error("symbol counter too narrow");
   end

endmodule

`default_nettype wire

// File: design/code128_pair_barcode_encoder.sv
// A number's first element reaches rsp through the classifier stages, queue and sequencer output register.
// Each valid number leaves the back-end sequencer as 55 bar/space elements, one rsp transfer per element,
// held while rsp_tready is low; a number rejected for a bad digit or pair gives one error result.
// The 3-stage classifier and the queue keep accepting while the sequencer is busy, until the queue is full.
// Reset: synchronous, active high; clears pipeline valids, queue pointers and sequencer.
`default_nettype none

module code128_pair_barcode_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // [55:0] digits_bcd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [2:0] module_width, [7:3] zero
   output logic [2:0]       rsp_tuser,   // [0] is_bar, [2:1] status
   output logic             rsp_tlast
);

   logic                       fr_valid, fr_ready;
   c128p_pkg::entry_type       fr_entry;
   c128p_pkg::queue_head_type  head;
   logic                       pop;
   logic [2:0]                 width;
   logic                       bar;
   logic [1:0]                 status;

   // Classify numbers and compute the check value
   c128p_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_digits (req_tdata),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_entry (fr_entry)
   );

   // Decouple classifier from sequencer
   c128p_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_entry (fr_entry),
      .head       (head),
      .pop        (pop)
   );

   // Sequence bar and space widths
   c128p_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_width  (width),
      .out_bar    (bar),
      .out_status (status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, width};
   assign rsp_tuser = {status, bar};

   // An error result is a single zero-width closing transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != c128p_pkg::STATUS_OK) |-> rsp_tlast && (width == 3'd0) && !bar)
      else $error("malformed error result");

   // Every symbol element has a width of one to four modules
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == c128p_pkg::STATUS_OK) |-> (width != 3'd0) && (width <= 3'd4))
      else $error("element width out of range");

   // The sequencer releases a number only when one is held
   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   // A released valid number ends on its last stop element
   assert property (@(posedge clock) disable iff (reset)
      pop && (head.entry.status == c128p_pkg::STATUS_OK) |=> rsp_tvalid && rsp_tlast)
      else $error("number released before its final element");

endmodule

`default_nettype wire
